// ----- rtl/pfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the page framebuffer scanout block.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int PAGE_COUNT  = 8;
  localparam int PAGE_WIDTH  = 128;
  localparam int PAD_TICKS   = 56;
  localparam int FILL_TICKS  = 19200;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CLR_W       = $clog2(STORE_DEPTH + 1);
  localparam int PAIRS       = PAGE_WIDTH / 2;
  localparam int ROW_TICKS   = PAIRS + PAD_TICKS;
  localparam int ROW_W       = $clog2(ROW_TICKS + 1);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int FILL_W      = $clog2(FILL_TICKS + 1);

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_PAINT = 3'd1;
  localparam logic [2:0] CMD_BLANK = 3'd2;
  localparam logic [2:0] CMD_ALLON = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PAINT,
    MODE_TRAILER,
    MODE_FILL
  } mode_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] byte_address;
    logic [7:0] byte_value;
    logic [7:0] trailer_high;
    logic [7:0] trailer_low;
  } in_t;

  typedef struct packed {
    logic data_select;
    logic line_even;
    logic line_odd;
    logic clock_pulse;
    logic sequence_end;
    logic busy_res;
  } out_t;

  // pin update issued by the controller for one beat
  typedef struct packed {
    logic       dc_wr;
    logic       dc;
    logic       ln_wr;
    logic       ln_ram;
    logic       even;
    logic       odd;
    logic [2:0] bit_sel;
    logic       pulse;
    logic       end_seq;
    logic       busy;
  } ctl_t;

endpackage
`default_nettype wire

// ----- rtl/page_framebuffer_two_bit_scanout.sv -----
`default_nettype none
// A result beat passes the issue register, with the store read data, then the
// result register; out_stall can hold it in either. Throughput: one beat per
// cycle while in_stall is low; both RAM read ports fetch a pixel pair in the
// accept cycle, so no beat waits on another. Reset: control state clears at once;
// then the 1024-byte store is cleared one byte per cycle, with in_stall high throughout.
// ----------------------------------------------------------------------------
// page_framebuffer_two_bit_scanout
// Page-ordered monochrome framebuffer with two-line raster scanout, trailer
// bytes and blank / all-on fills, advanced one display clock per tick beat.
// ----------------------------------------------------------------------------
module page_framebuffer_two_bit_scanout (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pfb_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output pfb_pkg::out_t      out_data
);

  import pfb_pkg::*;

  ctl_t              ctl;
  logic              accept;
  logic              s1_free;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [7:0]        rdata_a;
  logic [7:0]        rdata_b;

  pfb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .s1_free     (s1_free),
    .in_stall    (in_stall),
    .accept      (accept),
    .ctl         (ctl),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b)
  );

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  pfb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ctl       (ctl),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .out_stall (out_stall),
    .s1_free   (s1_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/pfb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pfb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_ctrl
// Sequencer: run mode, scan counters, trailer shifter, store clear pass and
// frame store addressing. Decides the pin update for each accepted beat.
// ----------------------------------------------------------------------------
module pfb_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire pfb_pkg::in_t                in_data,
  input  wire logic                        s1_free,
  output logic                             in_stall,
  output logic                             accept,
  output pfb_pkg::ctl_t                    ctl,
  output logic                             ram_we,
  output logic [pfb_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic [pfb_pkg::ADDR_W-1:0]       ram_raddr_a,
  output logic [pfb_pkg::ADDR_W-1:0]       ram_raddr_b
);

  import pfb_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [2:0]        brow_r, brow_nxt;
  logic [ROW_W-1:0]  rtick_r, rtick_nxt;
  logic [2:0]        ttick_r, ttick_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0]       tshift_r, tshift_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  logic              clearing;
  logic              is_tick;
  logic              in_pairs;

  assign clearing = (clr_r != CLR_W'(STORE_DEPTH));
  assign in_stall = clearing || !s1_free;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (in_data.cmd == CMD_TICK);
  assign in_pairs = (rtick_r < ROW_W'(PAIRS));
  assign clr_nxt  = clearing ? clr_r + CLR_W'(1) : clr_r;

  assign ram_raddr_a = ADDR_W'(int'(page_r) * PAGE_WIDTH + 2 * int'(rtick_r));
  assign ram_raddr_b = ram_raddr_a + ADDR_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_data.byte_address;
    ram_wdata = in_data.byte_value;
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r[ADDR_W-1:0];
      ram_wdata = 8'd0;
    end else if (accept && mode_r == MODE_IDLE && in_data.cmd == CMD_WRITE) begin
      ram_we = 1'b1;
    end
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    page_nxt   = page_r;
    brow_nxt   = brow_r;
    rtick_nxt  = rtick_r;
    ttick_nxt  = ttick_r;
    fill_nxt   = fill_r;
    tshift_nxt = tshift_r;
    if (accept) begin
      case (mode_r)
        MODE_IDLE: begin
          if (in_data.cmd == CMD_PAINT) begin
            mode_nxt   = MODE_PAINT;
            page_nxt   = '0;
            brow_nxt   = '0;
            rtick_nxt  = '0;
            ttick_nxt  = '0;
            tshift_nxt = {in_data.trailer_high, in_data.trailer_low};
          end else if (in_data.cmd == CMD_BLANK || in_data.cmd == CMD_ALLON) begin
            mode_nxt = MODE_FILL;
            fill_nxt = '0;
          end
        end
        MODE_PAINT: begin
          if (is_tick) begin
            rtick_nxt = rtick_r + ROW_W'(1);
            if (rtick_r == ROW_W'(ROW_TICKS - 1)) begin
              rtick_nxt = '0;
              brow_nxt  = brow_r + 3'd1;
              if (brow_r == 3'd7) begin
                page_nxt = page_r + PAGE_W'(1);
                if (page_r == PAGE_W'(PAGE_COUNT - 1)) begin
                  page_nxt  = '0;
                  mode_nxt  = MODE_TRAILER;
                  ttick_nxt = '0;
                end
              end
            end
          end
        end
        MODE_TRAILER: begin
          if (is_tick) begin
            tshift_nxt = {tshift_r[13:0], 2'b00};
            ttick_nxt  = ttick_r + 3'd1;
            if (ttick_r == 3'd7) begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
        MODE_FILL: begin
          if (is_tick) begin
            if (fill_r < FILL_W'(FILL_TICKS)) begin
              fill_nxt = fill_r + FILL_W'(1);
            end else begin
              fill_nxt = '0;
              mode_nxt = MODE_IDLE;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  // pin update for the beat
  always_comb begin
    ctl         = '0;
    ctl.bit_sel = brow_r;
    ctl.busy    = (mode_r != MODE_IDLE);
    case (mode_r)
      MODE_IDLE: begin
        if (in_data.cmd == CMD_PAINT) begin
          // paint start raises data/command only; lines hold their levels
          ctl.dc_wr = 1'b1;
          ctl.dc    = 1'b1;
          ctl.busy  = 1'b1;
        end else if (in_data.cmd == CMD_BLANK || in_data.cmd == CMD_ALLON) begin
          ctl.dc_wr = 1'b1;
          ctl.dc    = 1'b1;
          ctl.ln_wr = 1'b1;
          ctl.even  = (in_data.cmd == CMD_ALLON);
          ctl.odd   = (in_data.cmd == CMD_ALLON);
          ctl.busy  = 1'b1;
        end
      end
      MODE_PAINT: begin
        if (is_tick) begin
          ctl.pulse  = 1'b1;
          ctl.ln_wr  = 1'b1;
          ctl.ln_ram = in_pairs;
        end
      end
      MODE_TRAILER: begin
        if (is_tick) begin
          ctl.pulse   = 1'b1;
          ctl.dc_wr   = 1'b1;
          ctl.ln_wr   = 1'b1;
          ctl.even    = tshift_r[15];
          ctl.odd     = tshift_r[14];
          ctl.end_seq = (ttick_r == 3'd7);
        end
      end
      MODE_FILL: begin
        if (is_tick) begin
          ctl.pulse = 1'b1;
          if (fill_r >= FILL_W'(FILL_TICKS)) begin
            ctl.dc_wr   = 1'b1;
            ctl.end_seq = 1'b1;
          end
        end
      end
      default: begin
        ctl.busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      page_r   <= '0;
      brow_r   <= '0;
      rtick_r  <= '0;
      ttick_r  <= '0;
      fill_r   <= '0;
      tshift_r <= '0;
      clr_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      page_r   <= page_nxt;
      brow_r   <= brow_nxt;
      rtick_r  <= rtick_nxt;
      ttick_r  <= ttick_nxt;
      fill_r   <= fill_nxt;
      tshift_r <= tshift_nxt;
      clr_r    <= clr_nxt;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !accept)
    else $error("beat accepted during store clear");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !clearing) |-> (mode_r == MODE_IDLE))
    else $error("store written while sequence running");

  a_row_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    rtick_r < ROW_W'(ROW_TICKS))
    else $error("row tick counter out of range");

endmodule
`default_nettype wire

// ----- rtl/pfb_out.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_out
// Issue register and result register: applies the pin update of each beat,
// picks pixel bits from the store read data and holds the result beat.
// ----------------------------------------------------------------------------
module pfb_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire pfb_pkg::ctl_t  ctl,
  input  wire logic [7:0]     rdata_a,
  input  wire logic [7:0]     rdata_b,
  input  wire logic           out_stall,
  output logic                s1_free,
  output logic                out_valid,
  output pfb_pkg::out_t       out_data
);

  import pfb_pkg::*;

  ctl_t ctl_r;
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;
  logic dc_r, even_r, odd_r;
  logic dc_nxt, even_nxt, odd_nxt;
  logic s1_adv;
  logic move;

  assign s1_adv        = !out_valid_r || !out_stall;
  assign s1_free       = !s1_valid_r || s1_adv;
  assign move          = s1_valid_r && s1_adv;
  assign s1_valid_nxt  = accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_comb begin
    dc_nxt   = ctl_r.dc_wr ? ctl_r.dc : dc_r;
    even_nxt = even_r;
    odd_nxt  = odd_r;
    if (ctl_r.ln_wr) begin
      if (ctl_r.ln_ram) begin
        even_nxt = rdata_a[ctl_r.bit_sel];
        odd_nxt  = rdata_b[ctl_r.bit_sel];
      end else begin
        even_nxt = ctl_r.even;
        odd_nxt  = ctl_r.odd;
      end
    end
    out_nxt.data_select  = dc_nxt;
    out_nxt.line_even    = even_nxt;
    out_nxt.line_odd     = odd_nxt;
    out_nxt.clock_pulse  = ctl_r.pulse;
    out_nxt.sequence_end = ctl_r.end_seq;
    out_nxt.busy_res     = ctl_r.busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dc_r        <= 1'b0;
      even_r      <= 1'b0;
      odd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (move) begin
        dc_r   <= dc_nxt;
        even_r <= even_nxt;
        odd_r  <= odd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r <= ctl;
    end
    if (move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_end_has_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.sequence_end) |-> out_r.clock_pulse)
    else $error("sequence end without clock pulse");

  a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.clock_pulse) |-> out_r.busy_res)
    else $error("clock pulse while idle");

  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(ctl_r)))
    else $error("issue stage lost a held beat");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives write, paint, fill, tick and spare command beats into the page
// framebuffer scanout block and checks every result beat against a cycle-free
// predictor of the frame store, scan counters, trailer shifter and pin levels.
// Paints and fills always run to completion; both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import pfb_pkg::*;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;

  class scanout_scoreboard;
    logic [7:0]  frame [STORE_DEPTH];
    mode_t       mode;
    int unsigned page_idx, row_bit, row_tick, trailer_ticks, fill_ticks;
    logic [15:0] trailer_bits;
    logic        dc, even, odd;
    out_t        expected_pins [$];
    int unsigned errors;
    string       field_names [6] = '{"data_select", "line_even", "line_odd",
                                     "clock_pulse", "sequence_end", "busy_res"};

    function new();
      foreach (frame[i]) frame[i] = '0;
      mode          = MODE_IDLE;
      page_idx      = 0;
      row_bit       = 0;
      row_tick      = 0;
      trailer_ticks = 0;
      fill_ticks    = 0;
      trailer_bits  = '0;
      {dc, even, odd} = '0;
      errors        = 0;
    endfunction

    function bit busy();
      return mode != MODE_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function void note_input(in_t beat);
      out_t             r;
      logic [ADDR_W-1:0] addr;
      r = '0;
      r.busy_res = (mode != MODE_IDLE);
      if (mode == MODE_IDLE) begin
        case (beat.cmd)
          CMD_WRITE: frame[beat.byte_address] = beat.byte_value;
          CMD_PAINT: begin
            mode          = MODE_PAINT;
            page_idx      = 0;
            row_bit       = 0;
            row_tick      = 0;
            trailer_ticks = 0;
            trailer_bits  = {beat.trailer_high, beat.trailer_low};
            dc            = 1'b1;
            r.busy_res    = 1'b1;
          end
          CMD_BLANK, CMD_ALLON: begin
            mode       = MODE_FILL;
            fill_ticks = 0;
            even       = (beat.cmd == CMD_ALLON);
            odd        = (beat.cmd == CMD_ALLON);
            dc         = 1'b1;
            r.busy_res = 1'b1;
          end
          default: ;
        endcase
      end else if (beat.cmd == CMD_TICK) begin
        r.clock_pulse = 1'b1;
        case (mode)
          MODE_PAINT: begin
            if (row_tick < PAIRS) begin
              addr = ADDR_W'(page_idx * PAGE_WIDTH + 2 * row_tick);
              even = frame[addr][row_bit];
              odd  = frame[ADDR_W'(addr + 1)][row_bit];
            end else begin
              even = 1'b0;
              odd  = 1'b0;
            end
            row_tick++;
            if (row_tick >= ROW_TICKS) begin
              row_tick = 0;
              row_bit++;
              if (row_bit >= 8) begin
                row_bit = 0;
                page_idx++;
                if (page_idx >= PAGE_COUNT) begin
                  page_idx      = 0;
                  mode          = MODE_TRAILER;
                  trailer_ticks = 0;
                end
              end
            end
          end
          MODE_TRAILER: begin
            dc           = 1'b0;
            even         = trailer_bits[15];
            odd          = trailer_bits[14];
            trailer_bits = trailer_bits << 2;
            trailer_ticks++;
            if (trailer_ticks >= 8) begin
              trailer_ticks  = 0;
              mode           = MODE_IDLE;
              r.sequence_end = 1'b1;
            end
          end
          default: begin
            if (fill_ticks < FILL_TICKS) begin
              fill_ticks++;
            end else begin
              dc             = 1'b0;
              fill_ticks     = 0;
              mode           = MODE_IDLE;
              r.sequence_end = 1'b1;
            end
          end
        endcase
      end
      r.data_select = dc;
      r.line_even   = even;
      r.line_odd    = odd;
      expected_pins.push_back(r);
    endfunction

    function void check_result(out_t got);
      logic [5:0] g, w;
      int         i;
      if (expected_pins.size() == 0) begin
        $error("result beat with nothing expected: %b", got);
        errors++;
        return;
      end
      w = expected_pins.pop_front();
      g = got;
      for (i = 0; i < 6; i++) begin
        if (g[5 - i] !== w[5 - i]) begin
          $error("%s: expected %b, got %b", field_names[i], w[5 - i], g[5 - i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  scanout_scoreboard scanout_sb;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  page_framebuffer_two_bit_scanout u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check, then pick next stall (random or long hold-off)
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) scanout_sb.check_result(out_data);
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_granted < hold_requests) begin
        holds_granted++;
        hold_left = LONG_HOLD;
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < out_idle_pct);
    end
  end

  function automatic in_t make_beat(logic [2:0] cmd);
    in_t b;
    b.cmd          = cmd;
    b.byte_address = 10'($urandom_range(STORE_DEPTH - 1));
    b.byte_value   = 8'($urandom_range(255));
    b.trailer_high = 8'($urandom_range(255));
    b.trailer_low  = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    scanout_sb.note_input(beat);
  endtask

  task automatic send_cmd(logic [2:0] cmd);
    send_beat(make_beat(cmd));
  endtask

  task automatic send_write(logic [ADDR_W-1:0] addr, logic [7:0] value);
    in_t b;
    b              = make_beat(CMD_WRITE);
    b.byte_address = addr;
    b.byte_value   = value;
    send_beat(b);
  endtask

  // ticks until the running sequence ends, with ignored commands mixed in
  task automatic run_to_idle(int noise_pct);
    logic [2:0] cmd;
    while (scanout_sb.busy()) begin
      if ($urandom_range(99) < noise_pct) begin
        cmd = 3'($urandom_range(6));
        if (cmd >= CMD_TICK) cmd = cmd + 3'd1;
        send_cmd(cmd);
      end else begin
        send_cmd(CMD_TICK);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (scanout_sb.pending() != 0);
  endtask

  initial begin
    in_t b;
    int  phase, n, pick;
    scanout_sb   = new();
    in_idle_pct  = 6;
    out_idle_pct = 59;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // idle: tick and spare codes do nothing
    send_cmd(CMD_TICK);
    for (n = CMD_SPARE_FIRST; n <= CMD_SPARE_LAST; n++) send_cmd(3'(n));
    send_write(10'd0, 8'hFF);
    send_write(10'd1, 8'h00);
    send_write(10'd127, 8'h80);
    send_write(10'd128, 8'h01);
    send_write(10'd1022, 8'h55);
    send_write(10'd1023, 8'hFF);

    b              = make_beat(CMD_PAINT);
    b.trailer_high = 8'hFF;
    b.trailer_low  = 8'h00;
    send_beat(b);
    // everything but tick is dropped while busy
    send_write(10'd0, 8'h00);
    send_cmd(CMD_PAINT);
    send_cmd(CMD_BLANK);
    send_cmd(CMD_ALLON);
    for (n = CMD_SPARE_FIRST; n <= CMD_SPARE_LAST; n++) send_cmd(3'(n));
    run_to_idle(0);
    send_cmd(CMD_TICK);

    send_cmd(CMD_ALLON);
    send_cmd(CMD_WRITE);
    send_cmd(CMD_SPARE_LAST);
    run_to_idle(0);
    send_cmd(CMD_TICK);

    for (phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 59 : 0;
      out_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 6 : 0;
      n = $urandom_range(300, 360);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 70) send_cmd(CMD_WRITE);
        else if (pick < 88) send_cmd(CMD_TICK);
        else send_cmd(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)));
      end
      wait_drained();
      send_cmd(CMD_PAINT);
      if (phase == 2) hold_requests++;
      run_to_idle(4);
      repeat ($urandom_range(5, 20)) send_cmd(CMD_WRITE);
      if (phase == 0) send_cmd(CMD_BLANK);
      else if (phase == 1) send_cmd(CMD_ALLON);
      else send_cmd($urandom_range(1) ? CMD_ALLON : CMD_BLANK);
      run_to_idle(4);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scanout_sb.errors == 0 && scanout_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pfb_pkg.sv
rtl/pfb_ram.sv
rtl/pfb_ctrl.sv
rtl/pfb_out.sv
rtl/page_framebuffer_two_bit_scanout.sv
sim/testbench.sv
